[rtl/wstq_pkg.sv]
// ----------------------------------------------------------------------------
// wstq_pkg
// shared types and constants for the work-stealing task queue block
// ----------------------------------------------------------------------------
package wstq_pkg;

    // default pool and queue sizes
    localparam int MAX_WORKERS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int TASK_W   = 16;
    localparam int WORKER_W = 3;
    localparam int SRC_W    = 3;
    localparam int CFG_W    = 4;

    // stream data widths (fields packed, zero filled to bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // apb
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register indexes
    localparam int REG_WORKERS_IN_USE = 0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_WORKER = 2'd1,
        CMD_MAIN   = 2'd2
    } cmd_t;

    // outcome of one request, handed from the scheduler to the response stage
    typedef struct packed {
        logic             found;
        logic             stolen;
        logic             dropped;
        logic [SRC_W-1:0] src;
    } sched_res_t;

endpackage

[rtl/wstq_store.sv]
// ----------------------------------------------------------------------------
// wstq_store
// task id memory, one shared address, registered read data
// ----------------------------------------------------------------------------
module wstq_store import wstq_pkg::*; #(
    parameter int AW = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [TASK_W-1:0] wdata,
    output logic [TASK_W-1:0] rdata
);

    logic [TASK_W-1:0] mem [2**AW];
    logic [TASK_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/wstq_sched.sv]
// ----------------------------------------------------------------------------
// wstq_sched
// per-queue head and count, round-robin push pointer and victim scan
// ----------------------------------------------------------------------------
module wstq_sched import wstq_pkg::*; #(
    parameter  int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int QW          = $clog2(MAX_WORKERS),
    localparam int SW          = $clog2(QUEUE_DEPTH),
    localparam int AW          = QW + SW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  cmd_t                cmd,
    input  logic [WORKER_W-1:0] worker,
    input  logic [CFG_W-1:0]    workers_in_use,
    output logic                mem_we,
    output logic                mem_re,
    output logic [AW-1:0]       mem_addr,
    output sched_res_t          res
);

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW = CW + 1;
    localparam int IW   = ((QW > CFG_W) ? QW : CFG_W) + 1;
    localparam int WIW  = (IW > WORKER_W) ? IW : WORKER_W + 1;

    logic [SW-1:0] head_reg  [MAX_WORKERS];
    logic [CW-1:0] count_reg [MAX_WORKERS];
    logic [QW-1:0] ptr_reg;
    logic [QW-1:0] ptr_next;

    logic [IW-1:0]          pool;
    logic [MAX_WORKERS-1:0] active;
    logic [MAX_WORKERS-1:0] hi_mask;
    logic [MAX_WORKERS-1:0] lo_mask;
    logic [QW-1:0]          main_q;
    logic [QW-1:0]          hi_q;
    logic [QW-1:0]          lo_q;
    logic [QW-1:0]          push_q;
    logic [QW-1:0]          wk_q;
    logic                   wk_ok;

    logic [QW-1:0]   tgt;
    logic            do_push;
    logic            do_back;
    logic            do_front;
    logic [SW-1:0]   head_cur;
    logic [CW-1:0]   cnt_cur;
    logic [SUMW-1:0] sum;
    logic [SW-1:0]   slot;
    logic [SW-1:0]   head_inc;

    // clamp the register to 1..MAX_WORKERS
    always_comb begin
        if (workers_in_use == '0) begin
            pool = IW'(1);
        end else if (IW'(workers_in_use) > IW'(MAX_WORKERS)) begin
            pool = IW'(MAX_WORKERS);
        end else begin
            pool = IW'(workers_in_use);
        end
    end

    // non-empty flags and priority encoders, lowest index wins
    always_comb begin
        main_q = '0;
        hi_q   = '0;
        lo_q   = '0;
        for (int i = 0; i < MAX_WORKERS; i++) begin
            active[i]  = (IW'(i) < pool) && (count_reg[i] != '0);
            hi_mask[i] = active[i] && (WIW'(i) > WIW'(worker));
            lo_mask[i] = active[i] && (WIW'(i) < WIW'(worker));
        end
        for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
            if (active[i]) begin
                main_q = QW'(i);
            end
            if (hi_mask[i]) begin
                hi_q = QW'(i);
            end
            if (lo_mask[i]) begin
                lo_q = QW'(i);
            end
        end
    end

    assign push_q = (IW'(ptr_reg) < pool) ? ptr_reg : '0;
    assign wk_ok  = WIW'(worker) < WIW'(pool);
    assign wk_q   = QW'(worker);

    always_comb begin
        tgt      = '0;
        do_push  = 1'b0;
        do_back  = 1'b0;
        do_front = 1'b0;
        res      = '0;
        case (cmd)
            CMD_PUSH: begin
                tgt         = push_q;
                res.src     = SRC_W'(push_q);
                res.dropped = count_reg[push_q] >= CW'(QUEUE_DEPTH);
                do_push     = !res.dropped;
            end
            CMD_WORKER: begin
                if (wk_ok && count_reg[wk_q] != '0) begin
                    tgt       = wk_q;
                    do_back   = 1'b1;
                    res.found = 1'b1;
                    res.src   = SRC_W'(wk_q);
                end else if (wk_ok && (hi_mask != '0 || lo_mask != '0)) begin
                    // steal wraps past the end of the pool
                    tgt        = (hi_mask != '0) ? hi_q : lo_q;
                    do_front   = 1'b1;
                    res.found  = 1'b1;
                    res.stolen = 1'b1;
                    res.src    = SRC_W'(tgt);
                end
            end
            CMD_MAIN: begin
                if (active != '0) begin
                    tgt        = main_q;
                    do_front   = 1'b1;
                    res.found  = 1'b1;
                    res.stolen = 1'b1;
                    res.src    = SRC_W'(main_q);
                end
            end
            default: begin
            end
        endcase
    end

    // slot arithmetic, sum stays below twice the depth
    assign head_cur = head_reg[tgt];
    assign cnt_cur  = count_reg[tgt];
    assign sum      = SUMW'(head_cur) + SUMW'(cnt_cur) - (do_back ? SUMW'(1) : SUMW'(0));
    assign head_inc = (SUMW'(head_cur) == SUMW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + SW'(1);

    always_comb begin
        if (do_front) begin
            slot = head_cur;
        end else if (sum >= SUMW'(QUEUE_DEPTH)) begin
            slot = SW'(sum - SUMW'(QUEUE_DEPTH));
        end else begin
            slot = SW'(sum);
        end
    end

    assign mem_we   = fire && do_push;
    assign mem_re   = fire && (do_back || do_front);
    assign mem_addr = {tgt, slot};

    always_comb begin
        ptr_next = ptr_reg;
        if (fire && cmd == CMD_PUSH) begin
            ptr_next = (IW'(push_q) + IW'(1) == pool) ? '0 : push_q + QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            for (int i = 0; i < MAX_WORKERS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            ptr_reg <= ptr_next;
            if (fire && do_push) begin
                count_reg[tgt] <= cnt_cur + CW'(1);
            end
            if (fire && do_back) begin
                count_reg[tgt] <= cnt_cur - CW'(1);
            end
            if (fire && do_front) begin
                count_reg[tgt] <= cnt_cur - CW'(1);
                head_reg[tgt]  <= head_inc;
            end
        end
    end

endmodule

[rtl/work_stealing_task_queues.sv]
// ----------------------------------------------------------------------------
// work_stealing_task_queues
// bounded per-worker task deques with round-robin push and work stealing
// ----------------------------------------------------------------------------
// requests arrive on the s_ stream: push a task id, a worker fetch (own back,
// else steal the front of the next non-empty queue after the worker), or a
// main-thread fetch (front of the first non-empty queue from queue 0).
// every request gives exactly one result transfer on the m_ stream.
// the apb port holds workers_in_use (byte address 0), the active pool size.
// a request is accepted in the idle state and reads the single task memory
// port at the accept edge; its registered read data goes into the output
// register from the response state, before the next request is accepted.
// a finished result waits in the output register while the next request is
// accepted; if the receiver keeps stalling, the block holds the following
// result back and stops accepting until the output register frees up.
// reset clears all heads, counts and the push pointer and sets the pool to
// its full size; the task memory is not cleared, since entries are only read
// after a push wrote them. there is no clearing pass.
// configuration writes are expected while the block is idle.
// ----------------------------------------------------------------------------
module work_stealing_task_queues import wstq_pkg::*; #(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // cmd[1:0], task_id[17:2], worker[20:18]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // out_task[15:0], found[16],
                                             // source_queue[19:17], was_stolen[20],
                                             // push_dropped[21]
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int QW = $clog2(MAX_WORKERS);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int AW = QW + SW;
    // the register is 4 bits wide, so a larger pool resets to its largest value
    localparam logic [CFG_W-1:0] WORKERS_RESET =
        CFG_W'((MAX_WORKERS > 2**CFG_W - 1) ? 2**CFG_W - 1 : MAX_WORKERS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration register
    logic [CFG_W-1:0] workers_reg, workers_next;
    logic             cfg_wr;
    logic             cfg_hit;

    // request fields
    cmd_t                s_cmd;
    logic [TASK_W-1:0]   s_task_id;
    logic [WORKER_W-1:0] s_worker;
    logic                fire;

    // scheduler and memory
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [TASK_W-1:0] mem_rdata;
    sched_res_t        res;
    sched_res_t        pend_reg, pend_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [TASK_W-1:0] m_task_reg, m_task_next;
    sched_res_t        m_res_reg, m_res_next;
    logic              load_out;

    // ---------------- apb ----------------
    assign pready  = 1'b1;
    // only register 0 decodes
    assign cfg_hit = paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_WORKERS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? APB_DATA_W'(workers_reg) : '0;

    assign workers_next = cfg_wr ? pwdata[CFG_W-1:0] : workers_reg;

    // ---------------- request decode ----------------
    assign s_cmd     = cmd_t'(s_tdata[CMD_W-1:0]);
    assign s_task_id = s_tdata[CMD_W +: TASK_W];
    assign s_worker  = s_tdata[CMD_W + TASK_W +: WORKER_W];

    // one request in flight at a time
    assign s_tready = state_reg == ST_IDLE;
    assign fire     = s_tvalid && s_tready;

    wstq_sched #(
        .MAX_WORKERS (MAX_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_sched (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .cmd            (s_cmd),
        .worker         (s_worker),
        .workers_in_use (workers_reg),
        .mem_we         (mem_we),
        .mem_re         (mem_re),
        .mem_addr       (mem_addr),
        .res            (res)
    );

    wstq_store #(
        .AW (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_task_id),
        .rdata (mem_rdata)
    );

    // ---------------- control ----------------
    // read data stays put until the next read, so the response can wait
    assign load_out  = (state_reg == ST_RESP) && (!m_valid_reg || m_tready);
    assign pend_next = fire ? res : pend_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_task_next  = m_task_reg;
        m_res_next   = m_res_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_res_next   = pend_reg;
            m_task_next  = pend_reg.found ? mem_rdata : '0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            workers_reg <= WORKERS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            workers_reg <= workers_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_task_reg <= m_task_next;
        m_res_reg  <= m_res_next;
    end

    // ---------------- result stream ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_res_reg.dropped, m_res_reg.stolen, m_res_reg.src,
                                 m_res_reg.found, m_task_reg});

    // ---------------- checks ----------------
    a_accept_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> state_reg == ST_RESP)
        else $error("accepted request did not move to the response state");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP |-> !s_tready)
        else $error("request accepted while another is in flight");

    a_stolen_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_res_reg.stolen || m_res_reg.found))
        else $error("stolen flag without a task");

    a_drop_no_find: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_res_reg.dropped && m_res_reg.found))
        else $error("dropped push reported as a found task");

    a_mem_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("task memory read and write in one cycle");

endmodule

[verif/tb_work_stealing_task_queues.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_work_stealing_task_queues
// self-checking bench for the work-stealing task queue block
// ----------------------------------------------------------------------------
// requests go in on the s_ stream and results are compared field by field
// against a scheduler model kept in the bench (per-queue deques, round-robin
// push pointer, steal scan). a short table of directed requests covers the
// empty, wrap, stale-pointer, out-of-pool and undefined-command cases, then
// random phases walk through a range of pool sizes, filling and draining the
// queues. both streams idle at random, and one phase stalls the receiver
// long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module tb_work_stealing_task_queues;
    import wstq_pkg::*;

    localparam int MAXW          = MAX_WORKERS_DEF;
    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int DIR_ROWS      = 23;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 32;
    localparam int PRESSURE_PH   = 2;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_PRINTS    = 40;

    localparam logic [CMD_W-1:0]      CMD_UNDEF    = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_WORKERS = APB_ADDR_W'(REG_WORKERS_IN_USE * 4);

    // result fields, packed so that the lowest field lands in bit 0
    typedef struct packed {
        logic              push_dropped;
        logic              was_stolen;
        logic [SRC_W-1:0]  source_queue;
        logic              found;
        logic [TASK_W-1:0] out_task;
    } task_result_t;

    localparam int RES_W = $bits(task_result_t);
    localparam task_result_t NO_TASK = '0;

    // one row of the directed table: either a register write or a request
    typedef struct packed {
        bit                  is_cfg;
        logic [CFG_W-1:0]    cfg_val;
        logic [CMD_W-1:0]    cmd;
        logic [TASK_W-1:0]   task_id;
        logic [WORKER_W-1:0] worker;
        bit                  typed;
        task_result_t        want;
    } stim_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } phase_mode_t;

    // dut signals
    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // cmd[1:0], task_id[17:2], worker[20:18]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // out_task[15:0], found[16], source_queue[19:17],
                                      // was_stolen[20], push_dropped[21]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scheduler model state
    logic [TASK_W-1:0] tq_mem [MAXW][QDEPTH];
    int                tq_head [MAXW];
    int                tq_count [MAXW];
    int                rr_ptr;
    logic [CFG_W-1:0]  pool_reg;

    // expected results in request order
    task_result_t pending_results [$];

    // typed expectation of the request currently offered
    bit           cur_typed;
    task_result_t cur_typed_res;

    // idling controls shared with the receiver process
    bit hold_off_req;
    bit tx_free;
    bit rx_free;

    // bookkeeping
    int err_count;
    int req_count;
    int rsp_count;
    int cfg_count;
    int n_push;
    int n_drop;
    int n_local;
    int n_steal;
    int n_main;
    int n_empty;
    int n_undef;

    stim_row_t   dir_rows [DIR_ROWS];
    int          phase_pool [PHASES] = '{1, 1, 8, 2, 3, 8, 0, 5, 8, 15, 4, 6, 7, 8};
    phase_mode_t phase_mode [PHASES] = '{MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_FILL,
                                         MODE_MIX, MODE_FILL, MODE_MIX, MODE_DRAIN,
                                         MODE_MIX, MODE_MIX, MODE_FILL, MODE_DRAIN,
                                         MODE_MIX, MODE_DRAIN};

    work_stealing_task_queues i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // register value 0 acts as 1, anything above the pool maximum as the maximum
    function automatic int eff_pool(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > MAXW) return MAXW;
        return int'(v);
    endfunction

    // remove and return the oldest task of queue q
    function automatic logic [TASK_W-1:0] take_front(int q);
        int slot;
        slot = tq_head[q] % QDEPTH;
        tq_head[q] = (slot + 1) % QDEPTH;
        tq_count[q]--;
        return tq_mem[q][slot];
    endfunction

    // next state of the queues and the result of one request
    function automatic task_result_t predict_request(logic [CMD_W-1:0] cmd,
                                                     logic [TASK_W-1:0] tid,
                                                     logic [WORKER_W-1:0] wk);
        task_result_t r;
        int n;
        int q;
        int v;
        int slot;
        int i;
        bit hit;
        r = '0;
        hit = 1'b0;
        n = eff_pool(pool_reg);
        case (cmd)
            CMD_PUSH: begin
                // a pointer left over from a larger pool restarts at queue 0
                q = (rr_ptr < n) ? rr_ptr : 0;
                rr_ptr = (q + 1) % n;
                r.source_queue = SRC_W'(q);
                n_push++;
                if (tq_count[q] >= QDEPTH) begin
                    r.push_dropped = 1'b1;
                    n_drop++;
                end else begin
                    slot = (tq_head[q] + tq_count[q]) % QDEPTH;
                    tq_mem[q][slot] = tid;
                    tq_count[q]++;
                end
            end
            CMD_WORKER: begin
                if (int'(wk) < n) begin
                    if (tq_count[wk] != 0) begin
                        // own queue: newest task from the back
                        slot = (tq_head[wk] + tq_count[wk] - 1) % QDEPTH;
                        tq_count[wk]--;
                        r.out_task = tq_mem[wk][slot];
                        r.found = 1'b1;
                        r.source_queue = wk;
                        n_local++;
                    end else begin
                        // steal scan starts after the worker and wraps at the pool
                        for (i = 1; i < n && !hit; i++) begin
                            v = (int'(wk) + i) % n;
                            if (tq_count[v] != 0) begin
                                r.out_task = take_front(v);
                                r.found = 1'b1;
                                r.source_queue = SRC_W'(v);
                                r.was_stolen = 1'b1;
                                hit = 1'b1;
                                n_steal++;
                            end
                        end
                    end
                end
            end
            CMD_MAIN: begin
                for (i = 0; i < n && !hit; i++) begin
                    if (tq_count[i] != 0) begin
                        r.out_task = take_front(i);
                        r.found = 1'b1;
                        r.source_queue = SRC_W'(i);
                        r.was_stolen = 1'b1;
                        hit = 1'b1;
                        n_main++;
                    end
                end
            end
            default: begin
                n_undef++;
            end
        endcase
        if ((cmd == CMD_WORKER || cmd == CMD_MAIN) && !r.found) n_empty++;
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                     rsp_count, what, got, want);
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                                logic [WORKER_W-1:0] wk, bit typed, task_result_t want);
        int gap;
        gap = tx_free ? 0 : idle_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tdata       = {3'b000, wk, tid, cmd};
        cur_typed     = typed;
        cur_typed_res = want;
        s_tvalid      = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering, let every result come back, then let the pipe settle
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write workers_in_use and read it back
    task automatic write_pool(logic [CFG_W-1:0] val);
        quiesce();
        @(negedge aclk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = ADDR_WORKERS;
        pwdata = APB_DATA_W'(val);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        pool_reg = val;
        cfg_count++;
        // back-to-back read transfer, psel stays high
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(val))
            report_mismatch("workers_in_use readback", prdata, APB_DATA_W'(val));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // result checker and request tracker, both on the rising edge
    always @(posedge aclk) begin : monitor
        task_result_t got;
        task_result_t want;
        task_result_t pred;
        if (aresetn) begin
            // check first: a result never belongs to a request taken at the same edge
            if (m_tvalid && m_tready) begin
                got = task_result_t'(m_tdata[RES_W-1:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", got, 0);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.out_task !== want.out_task)
                        report_mismatch("out_task", got.out_task, want.out_task);
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.source_queue !== want.source_queue)
                        report_mismatch("source_queue", got.source_queue, want.source_queue);
                    if (got.was_stolen !== want.was_stolen)
                        report_mismatch("was_stolen", got.was_stolen, want.was_stolen);
                    if (got.push_dropped !== want.push_dropped)
                        report_mismatch("push_dropped", got.push_dropped, want.push_dropped);
                end
                rsp_count++;
            end
            if (s_tvalid && s_tready) begin
                pred = predict_request(s_tdata[1:0], s_tdata[17:2], s_tdata[20:18]);
                pending_results.insert(pending_results.size(),
                                       cur_typed ? cur_typed_res : pred);
                req_count++;
            end
        end
    end

    // receiver: random stalls, free flow on request, one long hold-off
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // long stall counted here while the sender keeps offering
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready = 1'b1;
            end else if (rx_free) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 65) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                stall_left = idle_gap();
            end
        end
    end

    // run limit
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int k;
        int p;
        int r;
        int n;
        int push_w;
        int fetch_w;
        int main_w;
        logic [CMD_W-1:0]    cmd;
        logic [TASK_W-1:0]   tid;
        logic [WORKER_W-1:0] wk;

        // all inputs known from time zero
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_typed    = 1'b0;
        cur_typed_res = NO_TASK;
        hold_off_req = 1'b0;
        tx_free      = 1'b0;
        rx_free      = 1'b0;
        err_count    = 0;
        req_count    = 0;
        rsp_count    = 0;
        cfg_count    = 0;
        n_push       = 0;
        n_drop       = 0;
        n_local      = 0;
        n_steal      = 0;
        n_main       = 0;
        n_empty      = 0;
        n_undef      = 0;

        // model state after reset: empty queues, pointer at 0, full pool
        for (k = 0; k < MAXW; k++) begin
            tq_head[k]  = 0;
            tq_count[k] = 0;
        end
        rr_ptr   = 0;
        pool_reg = CFG_W'(MAXW);

        // directed table, pool at its reset size of 8
        dir_rows = '{
            //  cfg   val    cmd         task_id    wk    typed  expected
            // empty pool: both fetch kinds find nothing, undefined command is inert
            '{1'b0, 4'd0,  CMD_MAIN,   16'h0000, 3'd0, 1'b1, NO_TASK},
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd7, 1'b1, NO_TASK},
            '{1'b0, 4'd0,  CMD_UNDEF,  16'hFFFF, 3'd7, 1'b1, NO_TASK},
            // round-robin pushes into queues 0, 1, 2
            '{1'b0, 4'd0,  CMD_PUSH,   16'hFFFF, 3'd7, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b0, 16'h0}},
            '{1'b0, 4'd0,  CMD_PUSH,   16'h0000, 3'd0, 1'b1, '{1'b0, 1'b0, 3'd1, 1'b0, 16'h0}},
            '{1'b0, 4'd0,  CMD_PUSH,   16'h1234, 3'd5, 1'b1, '{1'b0, 1'b0, 3'd2, 1'b0, 16'h0}},
            // local pop of a zero task id still reports found
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd1, 1'b1, '{1'b0, 1'b0, 3'd1, 1'b1, 16'h0}},
            // own queue empty: steal from the next one, then wrap from worker 7
            '{1'b0, 4'd0,  CMD_WORKER, 16'hFFFF, 3'd1, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd7, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_MAIN,   16'h0000, 3'd0, 1'b1, NO_TASK},
            '{1'b0, 4'd0,  CMD_PUSH,   16'h00FF, 3'd0, 1'b0, NO_TASK},
            // register 0 means a pool of one; the pointer at 4 is stale
            '{1'b1, 4'd0,  CMD_PUSH,   16'h0000, 3'd0, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_PUSH,   16'hA5A5, 3'd0, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b0, 16'h0}},
            // worker outside the pool gets nothing
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd1, 1'b1, NO_TASK},
            '{1'b0, 4'd0,  CMD_MAIN,   16'h0000, 3'd0, 1'b0, NO_TASK},
            // task left in queue 3 is out of reach with a pool of one
            '{1'b0, 4'd0,  CMD_MAIN,   16'h0000, 3'd0, 1'b1, NO_TASK},
            // register above the maximum clamps to 8
            '{1'b1, 4'd15, CMD_PUSH,   16'h0000, 3'd0, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_PUSH,   16'h8000, 3'd0, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd3, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_WORKER, 16'h0000, 3'd3, 1'b0, NO_TASK},
            '{1'b1, 4'd9,  CMD_PUSH,   16'h0000, 3'd0, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_PUSH,   16'h0001, 3'd2, 1'b0, NO_TASK},
            '{1'b0, 4'd0,  CMD_MAIN,   16'h0000, 3'd0, 1'b0, NO_TASK}
        };

        // synchronous reset
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].is_cfg)
                write_pool(dir_rows[k].cfg_val);
            else
                send_request(dir_rows[k].cmd, dir_rows[k].task_id, dir_rows[k].worker,
                             dir_rows[k].typed, dir_rows[k].want);
        end

        // random phases, one pool size each; queue contents carry over
        for (p = 0; p < PHASES; p++) begin
            write_pool(CFG_W'(phase_pool[p]));
            n = eff_pool(CFG_W'(phase_pool[p]));
            // two phases with no idling at all
            tx_free = (p == 5 || p == 9 || p == PRESSURE_PH);
            rx_free = (p == 5 || p == 9);
            if (p == PRESSURE_PH) hold_off_req = 1'b1;
            case (phase_mode[p])
                MODE_FILL: begin
                    push_w  = 90;
                    fetch_w = 5;
                    main_w  = 3;
                end
                MODE_DRAIN: begin
                    push_w  = 15;
                    fetch_w = 55;
                    main_w  = 28;
                end
                default: begin
                    push_w  = 45;
                    fetch_w = 35;
                    main_w  = 17;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < push_w)
                    cmd = CMD_PUSH;
                else if (r < push_w + fetch_w)
                    cmd = CMD_WORKER;
                else if (r < push_w + fetch_w + main_w)
                    cmd = CMD_MAIN;
                else
                    cmd = CMD_UNDEF;
                r = $urandom_range(0, 19);
                if (r == 0)
                    tid = 16'h0000;
                else if (r == 1)
                    tid = 16'hFFFF;
                else
                    tid = TASK_W'($urandom_range(0, 65535));
                // mostly workers inside the pool, some beyond it
                if ($urandom_range(0, 99) < 80)
                    wk = WORKER_W'($urandom_range(0, n - 1));
                else
                    wk = WORKER_W'($urandom_range(0, 7));
                send_request(cmd, tid, wk, 1'b0, NO_TASK);
            end
        end

        // drain and let any stray transfer show up
        tx_free = 1'b0;
        rx_free = 1'b1;
        quiesce();
        repeat (8) @(posedge aclk);

        $display("run covered %0d requests and %0d results across %0d pool settings",
                 req_count, rsp_count, cfg_count);
        $display("pushes %0d (dropped %0d), local pops %0d, steals %0d, main takes %0d,",
                 n_push, n_drop, n_local, n_steal, n_main);
        $display("misses %0d, undefined %0d", n_empty, n_undef);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[work_stealing_task_queues.f]
rtl/wstq_pkg.sv
rtl/wstq_store.sv
rtl/wstq_sched.sv
rtl/work_stealing_task_queues.sv
verif/tb_work_stealing_task_queues.sv
